>>> hw/rtl/multichannel_highpass_biquad_core_defines.svh
// ----------------------------------------------------------------------------
// multichannel highpass biquad - assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_HIGHPASS_BIQUAD_CORE_DEFINES_SVH
`define MULTICHANNEL_HIGHPASS_BIQUAD_CORE_DEFINES_SVH

// same-cycle implication
`define MHPBQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MHPBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mhpbq_pkg.sv
// ----------------------------------------------------------------------------
// mhpbq_pkg
// shared types and constants of the multichannel highpass biquad
// ----------------------------------------------------------------------------
package mhpbq_pkg;

    localparam int CHAN_BITS    = 4;
    localparam int COEF_BITS    = 32;
    localparam int CFG_IDX_BITS = 8;

    // request kinds carried in tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COEF_A0 = 8'd0,
        REG_COEF_A1 = 8'd1,
        REG_COEF_B1 = 8'd2,
        REG_COEF_B2 = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] a0;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
    } coef_set_t;

endpackage

>>> hw/rtl/mhpbq_ram.sv
// ----------------------------------------------------------------------------
// mhpbq_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mhpbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/mhpbq_cfg.sv
// ----------------------------------------------------------------------------
// mhpbq_cfg
// coefficient register file written over the configuration channel
// ----------------------------------------------------------------------------
module mhpbq_cfg
    import mhpbq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [CFG_IDX_BITS-1:0] wr_index,
    input  logic [COEF_BITS-1:0]    wr_data,
    output coef_set_t               coef
);

    coef_set_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_COEF_A0: coef_reg.a0 <= wr_data;
                REG_COEF_A1: coef_reg.a1 <= wr_data;
                REG_COEF_B1: coef_reg.b1 <= wr_data;
                REG_COEF_B2: coef_reg.b2 <= wr_data;
                default:     coef_reg <= coef_reg;
            endcase
        end
    end

    assign coef = coef_reg;

endmodule

>>> hw/rtl/mhpbq_mac.sv
// ----------------------------------------------------------------------------
// mhpbq_mac
// three-stage multiply, accumulate, round and saturate datapath
// ----------------------------------------------------------------------------
module mhpbq_mac
    import mhpbq_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                          clk,
    input  logic                          en,
    input  coef_set_t                     coef,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] x1,
    input  logic signed [SAMPLE_BITS-1:0] x2,
    input  logic signed [SAMPLE_BITS-1:0] y1,
    input  logic signed [SAMPLE_BITS-1:0] y2,
    output logic signed [SAMPLE_BITS-1:0] y,
    output logic signed [SAMPLE_BITS-1:0] wb_x1,
    output logic signed [SAMPLE_BITS-1:0] wb_x2,
    output logic signed [SAMPLE_BITS-1:0] wb_y2
);

    localparam int SB    = SAMPLE_BITS;
    localparam int XS_W  = SB + 1;
    localparam int P0_W  = XS_W + COEF_BITS;
    localparam int P_W   = SB + COEF_BITS;
    localparam int ACC_W = SB + COEF_BITS + 3;
    localparam int HI_LO = COEF_FRAC_BITS + SB - 1;
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SB-1:0]    S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0]    S_MIN = {1'b1, {(SB-1){1'b0}}};

    logic signed [XS_W-1:0]  xs;
    logic signed [P0_W-1:0]  p0_next, p0_reg;
    logic signed [P_W-1:0]   p1_next, p1_reg;
    logic signed [P_W-1:0]   p2_next, p2_reg;
    logic signed [P_W-1:0]   p3_next, p3_reg;
    logic signed [SB-1:0]    x_d1_reg, x1_d1_reg, y1_d1_reg;
    logic signed [ACC_W-1:0] sum_ff_next, sum_ff_reg;
    logic signed [ACC_W-1:0] sum_fb_next, sum_fb_reg;
    logic signed [SB-1:0]    x_d2_reg, x1_d2_reg, y1_d2_reg;
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-HI_LO-1:0]  acc_hi;
    logic                    fits;

    // stage 1: products
    assign xs      = XS_W'(x) + XS_W'(x2);
    assign p0_next = P0_W'(xs) * P0_W'(coef.a0);
    assign p1_next = P_W'(x1) * P_W'(coef.a1);
    assign p2_next = P_W'(y1) * P_W'(coef.b1);
    assign p3_next = P_W'(y2) * P_W'(coef.b2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            p3_reg    <= p3_next;
            x_d1_reg  <= x;
            x1_d1_reg <= x1;
            y1_d1_reg <= y1;
        end
    end

    // stage 2: feedforward and feedback partial sums, rounding half folded in
    assign sum_ff_next = ACC_W'(p0_reg) + ACC_W'(p1_reg) + HALF;
    assign sum_fb_next = ACC_W'(p2_reg) + ACC_W'(p3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_ff_reg <= sum_ff_next;
            sum_fb_reg <= sum_fb_next;
            x_d2_reg   <= x_d1_reg;
            x1_d2_reg  <= x1_d1_reg;
            y1_d2_reg  <= y1_d1_reg;
        end
    end

    // stage 3: final sum, floor by dropping fraction bits, clamp
    assign acc    = sum_ff_reg - sum_fb_reg;
    assign acc_hi = acc[ACC_W-1:HI_LO];
    assign fits   = (&acc_hi) | ~(|acc_hi);

    always_comb
    begin
        if (fits)
        begin
            y = acc[HI_LO:COEF_FRAC_BITS];
        end
        else if (acc[ACC_W-1])
        begin
            y = S_MIN;
        end
        else
        begin
            y = S_MAX;
        end
    end

    assign wb_x1 = x_d2_reg;
    assign wb_x2 = x1_d2_reg;
    assign wb_y2 = y1_d2_reg;

endmodule

>>> hw/rtl/multichannel_highpass_biquad_core.sv
// a sample passes the stage-1, stage-2, stage-3 and output registers to m_tvalid
// throughput: one item per cycle while the output is not stalled; a sample whose
//   channel is still among the three in flight waits for its history write-back, so
//   one channel repeating alone waits for each write-back (read-modify-write loop through the history ram)
// a clear item waits until no sample is in flight, then clears every channel history
// reset: coefficients zero, all channel histories read as zero, no pending results
// ----------------------------------------------------------------------------
// multichannel_highpass_biquad_core
// per-channel second-order highpass biquad with histories held in a ram
// ----------------------------------------------------------------------------
`include "multichannel_highpass_biquad_core_defines.svh"

module multichannel_highpass_biquad_core
    import mhpbq_pkg::*;
#(
    parameter int NUM_CHANNELS   = 16,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30,
    localparam int DATA_W = ((CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [DATA_W-1:0]       s_tdata,   // channel, sample_in
    input  logic [0:0]              s_tuser,   // req_type
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DATA_W-1:0]       m_tdata,   // out_channel, sample_out
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]    cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int HW = 4 * SB;

    coef_set_t             coef;
    logic [CHAN_BITS-1:0]  in_ch;
    logic signed [SB-1:0]  in_x;
    logic                  in_range;
    logic                  is_clear;
    logic                  hazard;
    logic                  busy;
    logic                  adv;
    logic                  accept;
    logic                  clear_go;
    logic                  out_load;
    logic                  wb_en;

    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [CHAN_BITS-1:0]  s1_ch_reg, s2_ch_reg, s3_ch_reg;
    logic signed [SB-1:0]  s1_x_reg;
    logic [AW-1:0]         s1_addr, s3_addr;
    logic [AW-1:0]         rd_addr;
    logic [HW-1:0]         rd_data;
    logic [HW-1:0]         wr_data;
    logic [NUM_CHANNELS-1:0] hist_valid_reg;
    logic                  s1_hist_ok;

    logic signed [SB-1:0]  h_x1, h_x2, h_y1, h_y2;
    logic signed [SB-1:0]  y, wb_x1, wb_x2, wb_y2;

    logic                  m_valid_reg;
    logic [CHAN_BITS-1:0]  m_ch_reg;
    logic signed [SB-1:0]  m_y_reg;

    logic                  ch_clash;
    logic                  s1_stall;

    // configuration
    assign cfg_ready = 1'b1;

    mhpbq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coef     (coef)
    );

    // input decode and interlock
    assign in_ch    = s_tdata[CHAN_BITS-1:0];
    assign in_x     = s_tdata[CHAN_BITS+SB-1:CHAN_BITS];
    assign in_range = (32'(in_ch) < NUM_CHANNELS);
    assign is_clear = (s_tuser[0] == REQ_CLEAR);

    assign busy   = s1_valid_reg | s2_valid_reg | s3_valid_reg;
    assign hazard = in_range & ((s1_valid_reg & (s1_ch_reg == in_ch)) |
                                (s2_valid_reg & (s2_ch_reg == in_ch)) |
                                (s3_valid_reg & (s3_ch_reg == in_ch)));

    // pipeline moves unless a result in the last stage cannot leave
    assign out_load = m_tready | ~m_valid_reg;
    assign adv      = out_load | ~s3_valid_reg;
    assign s_tready = adv & (is_clear ? ~busy : ~hazard);
    assign accept   = s_tvalid & s_tready;
    assign clear_go = accept & is_clear;
    assign wb_en    = adv & s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept & ~is_clear & in_range;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ch_reg <= in_ch;
            s1_x_reg  <= in_x;
            s2_ch_reg <= s1_ch_reg;
            s3_ch_reg <= s2_ch_reg;
        end
    end

    // history ram; while stalled the stage-1 entry is read again
    assign s1_addr = AW'(s1_ch_reg);
    assign s3_addr = AW'(s3_ch_reg);
    assign rd_addr = adv ? AW'(in_ch) : s1_addr;
    assign wr_data = {wb_y2, y, wb_x2, wb_x1};

    mhpbq_ram #(
        .WIDTH (HW),
        .DEPTH (NUM_CHANNELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (wb_en),
        .waddr (s3_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // entries not written since the last clear read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= '0;
        end
        else if (clear_go)
        begin
            hist_valid_reg <= '0;
        end
        else if (wb_en)
        begin
            hist_valid_reg[s3_addr] <= 1'b1;
        end
    end

    assign s1_hist_ok = hist_valid_reg[s1_addr];
    assign h_x1 = s1_hist_ok ? rd_data[SB-1:0]      : '0;
    assign h_x2 = s1_hist_ok ? rd_data[2*SB-1:SB]   : '0;
    assign h_y1 = s1_hist_ok ? rd_data[3*SB-1:2*SB] : '0;
    assign h_y2 = s1_hist_ok ? rd_data[4*SB-1:3*SB] : '0;

    mhpbq_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .en    (adv),
        .coef  (coef),
        .x     (s1_x_reg),
        .x1    (h_x1),
        .x2    (h_x2),
        .y1    (h_y1),
        .y2    (h_y2),
        .y     (y),
        .wb_x1 (wb_x1),
        .wb_x2 (wb_x2),
        .wb_y2 (wb_y2)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_ch_reg <= s3_ch_reg;
            m_y_reg  <= y;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'({m_y_reg, m_ch_reg});

    // one transaction per channel in flight at a time
    assign ch_clash = (s1_valid_reg & s2_valid_reg & (s1_ch_reg == s2_ch_reg)) |
                      (s1_valid_reg & s3_valid_reg & (s1_ch_reg == s3_ch_reg)) |
                      (s2_valid_reg & s3_valid_reg & (s2_ch_reg == s3_ch_reg));
    assign s1_stall = ~adv & s1_valid_reg;

    `MHPBQ_ASSERT_IMPL(a_distinct_ch, 1'b1, !ch_clash, "channel in flight twice")
    `MHPBQ_ASSERT_IMPL(a_wb_with_out, wb_en, out_load, "write-back without output load")
    `MHPBQ_ASSERT_NEXT(a_clear_empty, clear_go, hist_valid_reg == '0, "history not cleared")
    `MHPBQ_ASSERT_NEXT(a_stall_hold, s1_stall, s1_valid_reg && $stable(s1_ch_reg), "stage 1 moved")

endmodule
